[rtl/core/int8mm_pkg.sv]
// ----------------------------------------------------------------------------
// int8mm_pkg
// shared types and constants of the 4x4 int8 matrix multiply unit
// ----------------------------------------------------------------------------
package int8mm_pkg;

    localparam int unsigned DIM        = 4;
    localparam int unsigned ELEMS      = DIM * DIM;
    localparam int unsigned IDX_W      = $clog2(ELEMS);
    localparam int unsigned K_W        = $clog2(DIM);
    localparam int unsigned ELEM_W     = 8;
    localparam int unsigned PROD_W     = 2 * ELEM_W;
    localparam int unsigned ACC_W      = 18;
    localparam logic [ELEMS-1:0] MASK_RESET = '1;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a_elem;
        logic signed [ELEM_W-1:0] b_elem;
    } in_beat_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] product_elem;
        logic [IDX_W-1:0]        elem_index;
        logic                    last_elem;
    } out_beat_t;

    typedef struct packed {
        logic en;
        logic clr;
    } mac_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_OUT
    } state_t;

endpackage

[rtl/core/int8_matmul_4x4_masked_unit.sv]
// ----------------------------------------------------------------------------
// int8_matmul_4x4_masked_unit
// 4x4 signed int8 matrix multiply with per-position output mask
//
// Input channel (in_valid/in_ready/in_data): sixteen beats load A and B
// element pairs in row-major order, one beat per cycle while in_ready is
// high. After the sixteenth beat in_ready drops until all results are out.
// Output channel (out_valid/out_ready/out_data): sixteen result beats in
// row-major order, last_elem set on the final one. A position whose bit in
// the mask is clear returns zero.
// Each result is formed by one shared multiplier-accumulator over the k
// steps of ST_MAC, then held in the accumulator register in ST_OUT until
// it is accepted, after which the sequencer moves on to the next position.
// When out_ready is low the result holds and the sequencer waits.
// cfg_we writes cfg_wdata into the mask register; the mask in force at
// the sixteenth input beat is used for that matrix. Reset sets the mask to
// all ones and the load count to zero; stored elements are not cleared.
// ----------------------------------------------------------------------------
module int8_matmul_4x4_masked_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  int8mm_pkg::in_beat_t              in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output int8mm_pkg::out_beat_t             out_data,
    input  logic                              cfg_we,
    input  logic [int8mm_pkg::ELEMS-1:0]      cfg_wdata
);

    logic signed [int8mm_pkg::ELEM_W-1:0] a_mem [int8mm_pkg::ELEMS];
    logic signed [int8mm_pkg::ELEM_W-1:0] b_mem [int8mm_pkg::ELEMS];

    int8mm_pkg::state_t               state_reg, state_next;
    logic [int8mm_pkg::IDX_W-1:0]     load_cnt_reg, load_cnt_next;
    logic [int8mm_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [int8mm_pkg::K_W-1:0]       k_reg, k_next;
    logic [int8mm_pkg::ELEMS-1:0]     mask_reg, mask_next;
    logic [int8mm_pkg::ELEMS-1:0]     run_mask_reg, run_mask_next;

    logic                             in_fire;
    logic                             out_fire;
    int8mm_pkg::mac_ctrl_t            mac_ctrl;
    logic [int8mm_pkg::IDX_W-1:0]     a_addr, b_addr;
    logic signed [int8mm_pkg::ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic signed [int8mm_pkg::ACC_W-1:0] acc;

    assign in_ready  = (state_reg == int8mm_pkg::ST_LOAD);
    assign out_valid = (state_reg == int8mm_pkg::ST_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    // row of A from idx, column of B from idx, addressed by idx_next and k_next and registered
    assign a_addr = {idx_next[int8mm_pkg::IDX_W-1 -: int8mm_pkg::K_W], k_next};
    assign b_addr = {k_next, idx_next[int8mm_pkg::K_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_mem[load_cnt_reg] <= in_data.a_elem;
            b_mem[load_cnt_reg] <= in_data.b_elem;
        end
        a_rd_reg <= a_mem[a_addr];
        b_rd_reg <= b_mem[b_addr];
    end

    int8mm_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (mac_ctrl),
        .a     (a_rd_reg),
        .b     (b_rd_reg),
        .acc   (acc)
    );

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        idx_next      = idx_reg;
        k_next        = k_reg;
        mask_next     = cfg_we ? cfg_wdata : mask_reg;
        run_mask_next = run_mask_reg;
        mac_ctrl      = '0;
        unique case (state_reg)
            int8mm_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    load_cnt_next = load_cnt_reg + 1'b1;
                    if (load_cnt_reg == int8mm_pkg::IDX_W'(int8mm_pkg::ELEMS - 1))
                    begin
                        run_mask_next = mask_reg;
                        idx_next      = '0;
                        k_next        = '0;
                        state_next    = int8mm_pkg::ST_MAC;
                    end
                end
            end
            int8mm_pkg::ST_MAC:
            begin
                mac_ctrl.en  = 1'b1;
                mac_ctrl.clr = (k_reg == '0);
                k_next       = k_reg + 1'b1;
                if (k_reg == int8mm_pkg::K_W'(int8mm_pkg::DIM - 1))
                begin
                    state_next = int8mm_pkg::ST_OUT;
                end
            end
            int8mm_pkg::ST_OUT:
            begin
                if (out_fire)
                begin
                    idx_next = idx_reg + 1'b1;
                    if (idx_reg == int8mm_pkg::IDX_W'(int8mm_pkg::ELEMS - 1))
                    begin
                        state_next = int8mm_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = int8mm_pkg::ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = int8mm_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= int8mm_pkg::ST_LOAD;
            load_cnt_reg <= '0;
            idx_reg      <= '0;
            k_reg        <= '0;
            mask_reg     <= int8mm_pkg::MASK_RESET;
            run_mask_reg <= int8mm_pkg::MASK_RESET;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            idx_reg      <= idx_next;
            k_reg        <= k_next;
            mask_reg     <= mask_next;
            run_mask_reg <= run_mask_next;
        end
    end

    always_comb
    begin
        out_data.product_elem = run_mask_reg[idx_reg] ? acc : '0;
        out_data.elem_index   = idx_reg;
        out_data.last_elem    = (idx_reg == int8mm_pkg::IDX_W'(int8mm_pkg::ELEMS - 1));
    end

endmodule

[rtl/core/int8mm_mac.sv]
// ----------------------------------------------------------------------------
// int8mm_mac
// shared signed 8x8 multiplier with 18-bit accumulator
// ----------------------------------------------------------------------------
module int8mm_mac (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  int8mm_pkg::mac_ctrl_t                 ctrl,
    input  logic signed [int8mm_pkg::ELEM_W-1:0]  a,
    input  logic signed [int8mm_pkg::ELEM_W-1:0]  b,
    output logic signed [int8mm_pkg::ACC_W-1:0]   acc
);

    logic signed [int8mm_pkg::PROD_W-1:0] prod;
    logic signed [int8mm_pkg::ACC_W-1:0]  prod_ext;
    logic signed [int8mm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [int8mm_pkg::ACC_W-1:0]  acc_next;

    assign prod     = a * b;
    assign prod_ext = int8mm_pkg::ACC_W'(prod);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.en)
        begin
            acc_next = ctrl.clr ? prod_ext : acc_reg + prod_ext;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[tb/int8_matmul_4x4_masked_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// int8_matmul_4x4_masked_unit_tb
// Self-checking testbench for the 4x4 int8 matrix multiply unit. Sixteen
// A/B element pairs load each matrix pair. A scoreboard class keeps its own
// copy of both matrices and the position mask, and on each sixteenth beat it
// predicts the sixteen masked products. Each output beat is checked field
// by field against the oldest prediction. A directed matrix pair drives the
// product extremes. Random pairs then run under a range of mask settings and
// idle patterns, and one long stall on the output fills the unit.
// ----------------------------------------------------------------------------
module int8_matmul_4x4_masked_unit_tb;

    localparam logic [int8mm_pkg::ELEMS*int8mm_pkg::ELEM_W-1:0] DIRECTED_A =
        128'h9C64C040_FE01FF00_7F7F7F7F_80808080;
    localparam logic [int8mm_pkg::ELEMS*int8mm_pkg::ELEM_W-1:0] DIRECTED_B =
        128'h80557F80_7F007F80_00FF7F80_AB017F80;
    localparam int PHASES       = 11;

    class matmul_scoreboard;
        logic [int8mm_pkg::ELEMS-1:0]         mask;
        logic signed [int8mm_pkg::ELEM_W-1:0] a_store [int8mm_pkg::ELEMS];
        logic signed [int8mm_pkg::ELEM_W-1:0] b_store [int8mm_pkg::ELEMS];
        int unsigned                          loaded;
        int8mm_pkg::out_beat_t                pending_products [$];
        int unsigned                          errors;

        function new();
            mask   = int8mm_pkg::MASK_RESET;
            loaded = 0;
            errors = 0;
        endfunction

        function void set_mask(logic [int8mm_pkg::ELEMS-1:0] value);
            mask = value;
        endfunction

        function void report(string field, int want_v, int got_v);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
        endfunction

        function void note_pair(int8mm_pkg::in_beat_t beat);
            int8mm_pkg::out_beat_t res;
            int                    acc;
            int                    idx;
            a_store[loaded] = beat.a_elem;
            b_store[loaded] = beat.b_elem;
            if (loaded < int8mm_pkg::ELEMS - 1)
            begin
                loaded++;
                return;
            end
            loaded = 0;
            for (int r = 0; r < int8mm_pkg::DIM; r++)
            begin
                for (int c = 0; c < int8mm_pkg::DIM; c++)
                begin
                    idx = r * int8mm_pkg::DIM + c;
                    acc = 0;
                    if (mask[idx])
                    begin
                        for (int k = 0; k < int8mm_pkg::DIM; k++)
                            acc += int'(a_store[r * int8mm_pkg::DIM + k]) *
                                   int'(b_store[k * int8mm_pkg::DIM + c]);
                    end
                    res.product_elem = acc[int8mm_pkg::ACC_W-1:0];
                    res.elem_index   = idx[int8mm_pkg::IDX_W-1:0];
                    res.last_elem    = (idx == int8mm_pkg::ELEMS - 1);
                    pending_products.push_back(res);
                end
            end
        endfunction

        function void check_result(int8mm_pkg::out_beat_t got);
            int8mm_pkg::out_beat_t want;
            if (pending_products.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, actual %0d at %0d",
                         $time, got.product_elem, got.elem_index);
                return;
            end
            want = pending_products.pop_front();
            if (got.product_elem !== want.product_elem)
                report("product_elem", want.product_elem, got.product_elem);
            if (got.elem_index !== want.elem_index)
                report("elem_index", want.elem_index, got.elem_index);
            if (got.last_elem !== want.last_elem)
                report("last_elem", want.last_elem, got.last_elem);
        endfunction

        function int unsigned pending();
            return pending_products.size();
        endfunction
    endclass

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    int8mm_pkg::in_beat_t         in_data   = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    int8mm_pkg::out_beat_t        out_data;
    logic                         cfg_we    = 1'b0;
    logic [int8mm_pkg::ELEMS-1:0] cfg_wdata = '0;

    matmul_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_request   = 0;
    int hold_left      = 0;

    int8_matmul_4x4_masked_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // output side: check accepted beats, then decide next ready
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
                sb.check_result(out_data);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic logic [int8mm_pkg::ELEM_W-1:0] pick_elem();
        case ($urandom_range(7))
            0: return 8'h80;
            1: return 8'h7F;
            2: return 8'hFF;
            default: return int8mm_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    task automatic send_beat(input int8mm_pkg::in_beat_t beat);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= beat;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_pair(beat);
    endtask

    task automatic send_random_matrix();
        int8mm_pkg::in_beat_t beat;
        for (int i = 0; i < int8mm_pkg::ELEMS; i++)
        begin
            beat.a_elem = pick_elem();
            beat.b_elem = pick_elem();
            send_beat(beat);
        end
    endtask

    task automatic write_mask(input logic [int8mm_pkg::ELEMS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_mask(value);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int8mm_pkg::in_beat_t         beat;
        logic [int8mm_pkg::ELEMS-1:0] mask_value;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // product extremes under the reset mask
        for (int i = 0; i < int8mm_pkg::ELEMS; i++)
        begin
            beat.a_elem = DIRECTED_A[i * int8mm_pkg::ELEM_W +: int8mm_pkg::ELEM_W];
            beat.b_elem = DIRECTED_B[i * int8mm_pkg::ELEM_W +: int8mm_pkg::ELEM_W];
            send_beat(beat);
        end
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: mask_value = 16'h0000;
                1: mask_value = 16'hFFFF;
                2: mask_value = 16'h0001;
                3: mask_value = 16'h8000;
                4: mask_value = 16'hAAAA;
                default: mask_value = int8mm_pkg::ELEMS'($urandom);
            endcase
            write_mask(mask_value);
            case (p % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 70;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 70;
                end
                default:
                begin
                    send_idle_pct  = 35;
                    recv_stall_pct = 35;
                end
            endcase
            // long output stall while the next pair is offered
            if (p == 4)
                hold_request = 400;
            repeat (2) send_random_matrix();
            drain();
        end

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[int8_matmul_4x4_masked_unit.f]
rtl/core/int8mm_pkg.sv
rtl/core/int8mm_mac.sv
rtl/core/int8_matmul_4x4_masked_unit.sv
tb/int8_matmul_4x4_masked_unit_tb.sv
